### rtl/rhc_pkg.sv
// Package for the RGB to HSV converter: word types, constants and divider lane type.
`default_nettype none

package rhc_pkg;

  // Channel and result widths
  localparam int unsigned ChanWidth = 8;
  localparam int unsigned HueWidth  = 15;

  // One quotient bit is resolved per divider cell
  localparam int unsigned QuoWidth  = 12;
  localparam int unsigned NumCells  = QuoWidth;

  // Hue angles in 1/64 degree
  localparam logic [15:0] HueFullTurn  = 16'd23040;
  localparam logic [15:0] HueBaseRed   = 16'd0;
  localparam logic [15:0] HueBaseGreen = 16'd7680;
  localparam logic [15:0] HueBaseBlue  = 16'd15360;

  // Input word
  typedef struct packed {
    logic [ChanWidth-1:0] red;
    logic [ChanWidth-1:0] green;
    logic [ChanWidth-1:0] blue;
  } rhc_pixel_t;

  // Output word
  typedef struct packed {
    logic [HueWidth-1:0]  hue;
    logic [ChanWidth-1:0] saturation;
    logic [ChanWidth-1:0] value;
  } rhc_hsv_t;

  // Which channel is largest
  typedef enum logic [1:0] {
    SecRed,
    SecGreen,
    SecBlue
  } rhc_sector_e;

  // One restoring-division lane: partial remainder, dividend bits still to
  // shift in, divisor and quotient built so far
  typedef struct packed {
    logic [ChanWidth-1:0] rem;
    logic [QuoWidth-1:0]  num;
    logic [ChanWidth-1:0] den;
    logic [QuoWidth-1:0]  quo;
  } rhc_lane_t;

  // Data moving down the cell chain
  typedef struct packed {
    rhc_lane_t            sat;
    rhc_lane_t            hue;
    logic [ChanWidth-1:0] value;
    rhc_sector_e          sector;
    logic                 neg;
    logic                 grey;
  } rhc_div_t;

endpackage

`default_nettype wire

### rtl/rgb_to_hsv_converter.sv
// RGB to HSV converter: front stage, a chain of divider cells and an output stage.
//
// Usage:
//   Input channel in_valid_i / in_stall_o / in_word_i carries one RGB pixel per
//   word. Output channel out_valid_o / out_stall_i / out_word_o carries hue
//   (1/64 degree), saturation and value. A word moves when valid is high and
//   stall is low at a rising clock edge.
//   The pipeline is one front register, twelve divider cells (one
//   quotient bit of both the saturation and the hue division per cell) and
//   the output register. Throughput is one pixel per clock while the output
//   is not stalled; the cell chain holds up to 14 pixels in flight.
//   When the receiver stalls while a result waits in the output register,
//   the whole chain holds and in_stall_o rises in the same cycle; otherwise
//   the chain advances and empty slots are refilled.
//   Reset clears all valid flags; no result is presented until a new pixel
//   has passed through the chain.
`default_nettype none

module rgb_to_hsv_converter
  import rhc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire rhc_pixel_t in_word_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output rhc_hsv_t        out_word_o
);

  logic     advance;
  logic     chain_valid [NumCells+1];
  rhc_div_t chain_word  [NumCells+1];

  // Chain holds only while a finished result is blocked
  assign advance    = !(out_valid_o && out_stall_i);
  assign in_stall_o = !advance;

  rhc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .valid_i (in_valid_i),
    .word_i  (in_word_i),
    .valid_o (chain_valid[0]),
    .word_o  (chain_word[0])
  );

  // Divider cells, one quotient bit each
  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    rhc_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (advance),
      .valid_i (chain_valid[i]),
      .word_i  (chain_word[i]),
      .valid_o (chain_valid[i+1]),
      .word_o  (chain_word[i+1])
    );
  end

  rhc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .valid_i (chain_valid[NumCells]),
    .word_i  (chain_word[NumCells]),
    .valid_o (out_valid_o),
    .word_o  (out_word_o)
  );

endmodule

`default_nettype wire

### rtl/rhc_front.sv
// Front stage: max/min, sector pick, signed difference and both dividends.
`default_nettype none

module rhc_front
  import rhc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       en_i,
  input  wire logic       valid_i,
  input  wire rhc_pixel_t word_i,
  output logic            valid_o,
  output rhc_div_t        word_o
);

  logic [7:0]  hi;
  logic [7:0]  lo;
  logic [7:0]  delta;
  logic [8:0]  diff;
  logic [7:0]  mag;
  logic [15:0] sat_num;
  logic [19:0] hue_num;
  rhc_sector_e sector;
  rhc_div_t    word_d;
  rhc_div_t    word_q;
  logic        valid_q;

  // Largest and smallest channel
  always_comb begin
    hi = word_i.blue;
    if (hi < word_i.green) hi = word_i.green;
    if (hi < word_i.red)   hi = word_i.red;
    lo = word_i.blue;
    if (lo > word_i.green) lo = word_i.green;
    if (lo > word_i.red)   lo = word_i.red;
    delta = hi - lo;
  end

  // Sector and difference; red wins ties, then green
  always_comb begin
    priority if (word_i.red == hi) begin
      sector = SecRed;
      diff   = {1'b0, word_i.green} - {1'b0, word_i.blue};
    end else if (word_i.green == hi) begin
      sector = SecGreen;
      diff   = {1'b0, word_i.blue} - {1'b0, word_i.red};
    end else begin
      sector = SecBlue;
      diff   = {1'b0, word_i.red} - {1'b0, word_i.green};
    end
    mag = diff[8] ? 8'(-diff) : diff[7:0];
  end

  // Dividends: 255*delta and 3840*|diff|
  always_comb begin
    sat_num = {delta, 8'd0} - {8'd0, delta};
    hue_num = {mag, 12'd0} - {4'd0, mag, 8'd0};

    word_d.sat.rem = {4'd0, sat_num[15:12]};
    word_d.sat.num = sat_num[11:0];
    word_d.sat.den = hi;
    word_d.sat.quo = '0;
    word_d.hue.rem = hue_num[19:12];
    word_d.hue.num = hue_num[11:0];
    word_d.hue.den = delta;
    word_d.hue.quo = '0;
    word_d.value   = hi;
    word_d.sector  = sector;
    word_d.neg     = diff[8];
    word_d.grey    = (delta == 8'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

`default_nettype wire

### rtl/rhc_div_cell.sv
// Divider cell: resolves one quotient bit of both the saturation and hue lanes.
`default_nettype none

module rhc_div_cell
  import rhc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     en_i,
  input  wire logic     valid_i,
  input  wire rhc_div_t word_i,
  output logic          valid_o,
  output rhc_div_t      word_o
);

  // One restoring step: shift in next dividend bit, subtract if it fits
  function automatic rhc_lane_t lane_step(rhc_lane_t l);
    rhc_lane_t  r;
    logic [8:0] trial;
    r     = l;
    trial = {l.rem, l.num[QuoWidth-1]};
    r.num = {l.num[QuoWidth-2:0], 1'b0};
    if (trial >= {1'b0, l.den}) begin
      r.rem = 8'(trial - {1'b0, l.den});
      r.quo = {l.quo[QuoWidth-2:0], 1'b1};
    end else begin
      r.rem = trial[7:0];
      r.quo = {l.quo[QuoWidth-2:0], 1'b0};
    end
    return r;
  endfunction

  rhc_div_t word_d;
  rhc_div_t word_q;
  logic     valid_q;

  always_comb begin
    word_d     = word_i;
    word_d.sat = lane_step(word_i.sat);
    word_d.hue = lane_step(word_i.hue);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

`default_nettype wire

### rtl/rhc_back.sv
// Back stage: sector base plus signed offset, wrap, grey override; output register.
`default_nettype none

module rhc_back
  import rhc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     en_i,
  input  wire logic     valid_i,
  input  wire rhc_div_t word_i,
  output logic          valid_o,
  output rhc_hsv_t      word_o
);

  logic [15:0] base;
  logic [15:0] offset;
  logic [15:0] sum;
  logic [15:0] hue;
  rhc_hsv_t    word_d;
  rhc_hsv_t    word_q;
  logic        valid_q;

  // Sector base angle
  always_comb begin
    unique case (word_i.sector)
      SecRed:   base = HueBaseRed;
      SecGreen: base = HueBaseGreen;
      SecBlue:  base = HueBaseBlue;
      default:  base = HueBaseRed;
    endcase
  end

  // Truncated quotient applied with the difference's sign, then wrapped
  always_comb begin
    offset = {4'd0, word_i.hue.quo};
    sum    = word_i.neg ? (base - offset) : (base + offset);
    priority if (sum[15]) begin
      hue = sum + HueFullTurn;
    end else if (sum >= HueFullTurn) begin
      hue = sum - HueFullTurn;
    end else begin
      hue = sum;
    end

    word_d.value = word_i.value;
    if (word_i.grey) begin
      word_d.hue        = '0;
      word_d.saturation = '0;
    end else begin
      word_d.hue        = hue[HueWidth-1:0];
      word_d.saturation = word_i.sat.quo[ChanWidth-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

`default_nettype wire

### bench/rgb_to_hsv_converter_tb.sv
// Self-checking testbench for the RGB to HSV converter with random handshake gaps.
`default_nettype none

module rgb_to_hsv_converter_tb
  import rhc_pkg::*;
();

  localparam int HueSixth   = 3840;
  localparam int ChanFull   = 255;
  localparam int NumRandom  = 1450;
  localparam int IdleLimit  = 2000;
  localparam int SettleCyc  = 20;

  // One pending pixel; drain holds it back until every result is in
  typedef struct {
    rhc_pixel_t pixel;
    logic       drain;
  } pending_pixel_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  rhc_pixel_t in_word_i;
  logic       out_valid_o;
  logic       out_stall_i;
  rhc_hsv_t   out_word_o;

  pending_pixel_t pixel_q[$];
  rhc_hsv_t       hsv_q[$];

  int   mismatches = 0;
  int   idle_cycles = 0;
  int   gap_left = 0;
  int   stall_left = 0;
  logic in_burst = 1'b0;
  logic out_burst = 1'b0;
  logic in_took = 1'b0;
  logic out_took = 1'b0;

  rgb_to_hsv_converter u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  // Clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Expected HSV word for one pixel
  function automatic rhc_hsv_t hsv_of(rhc_pixel_t px);
    int r, g, b, hi, lo, span, base, diff, hue, sat;
    rhc_hsv_t res;
    r = int'(px.red);
    g = int'(px.green);
    b = int'(px.blue);
    hi = b;
    if (hi < g) hi = g;
    if (hi < r) hi = r;
    lo = b;
    if (lo > g) lo = g;
    if (lo > r) lo = r;
    span = hi - lo;
    hue = 0;
    sat = 0;
    // grey pixels keep hue and saturation at zero
    if (span != 0) begin
      sat = (ChanFull * span) / hi;
      // red wins ties, then green
      if (r == hi) begin
        base = int'(HueBaseRed);
        diff = g - b;
      end else if (g == hi) begin
        base = int'(HueBaseGreen);
        diff = b - r;
      end else begin
        base = int'(HueBaseBlue);
        diff = r - g;
      end
      // signed division truncates toward zero
      hue = base + (HueSixth * diff) / span;
      if (hue < 0) hue += int'(HueFullTurn);
      if (hue >= int'(HueFullTurn)) hue -= int'(HueFullTurn);
    end
    res.hue        = hue[HueWidth-1:0];
    res.saturation = sat[ChanWidth-1:0];
    res.value      = hi[ChanWidth-1:0];
    return res;
  endfunction

  // Random pixel, weighted toward grey, ties and near-extreme channels
  function automatic rhc_pixel_t random_pixel();
    rhc_pixel_t px;
    logic [7:0] lvl;
    px  = rhc_pixel_t'(24'($urandom));
    lvl = 8'($urandom);
    case ($urandom_range(0, 9))
      0: px = '{red: lvl, green: lvl, blue: lvl};
      1: px.green = px.red;
      2: px.blue = px.red;
      3: px.blue = px.green;
      4: begin
        px.red  = 8'd255 - 8'($urandom_range(0, 2));
        px.blue = 8'($urandom_range(0, 2));
      end
      default: ;
    endcase
    return px;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("ERROR %s: got %0d, expected %0d", what, got, want);
    mismatches++;
  endtask

  task automatic add_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic drain);
    pending_pixel_t item;
    item.pixel = '{red: r, green: g, blue: b};
    item.drain = drain;
    pixel_q.push_back(item);
  endtask

  // Stimulus and end of run
  initial begin
    pending_pixel_t item;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_word_i   = '0;
    out_stall_i = 1'b0;

    // directed: grey levels, primaries, ties, hue wrap below zero
    add_pixel(8'd0,   8'd0,   8'd0,   1'b0);
    add_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    add_pixel(8'd128, 8'd128, 8'd128, 1'b0);
    add_pixel(8'd255, 8'd0,   8'd0,   1'b0);
    add_pixel(8'd0,   8'd255, 8'd0,   1'b0);
    add_pixel(8'd0,   8'd0,   8'd255, 1'b0);
    add_pixel(8'd255, 8'd255, 8'd0,   1'b0);
    add_pixel(8'd255, 8'd0,   8'd255, 1'b0);
    add_pixel(8'd0,   8'd255, 8'd255, 1'b0);
    add_pixel(8'd1,   8'd1,   8'd0,   1'b0);
    add_pixel(8'd0,   8'd1,   8'd1,   1'b0);
    add_pixel(8'd1,   8'd0,   8'd1,   1'b0);
    add_pixel(8'd255, 8'd0,   8'd1,   1'b0);
    add_pixel(8'd255, 8'd254, 8'd0,   1'b0);
    add_pixel(8'd254, 8'd255, 8'd0,   1'b0);
    add_pixel(8'd0,   8'd254, 8'd255, 1'b0);
    add_pixel(8'd255, 8'd0,   8'd254, 1'b0);
    add_pixel(8'd1,   8'd0,   8'd0,   1'b0);
    add_pixel(8'd0,   8'd0,   8'd1,   1'b0);
    add_pixel(8'd200, 8'd10,  8'd100, 1'b0);
    add_pixel(8'd10,  8'd100, 8'd200, 1'b0);
    add_pixel(8'd100, 8'd200, 8'd10,  1'b0);

    // random part, with the sender draining the chain a few times
    for (int i = 0; i < NumRandom; i++) begin
      item.pixel = random_pixel();
      item.drain = (i == 0) || (i == NumRandom / 2) || (i == (3 * NumRandom) / 4);
      pixel_q.push_back(item);
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pixel_q.size() > 0 || in_valid_i || hsv_q.size() > 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);

    if (hsv_q.size() > 0) report_mismatch("results left over", 0, hsv_q.size());
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Driver: new word at the falling edge, held while stalled
  always @(negedge clk_i) begin
    pending_pixel_t item;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !in_took) begin
      // hold the word
    end else if (gap_left > 0) begin
      in_valid_i <= 1'b0;
      gap_left = gap_left - 1;
    end else if (pixel_q.size() > 0 && !(pixel_q[0].drain && hsv_q.size() > 0)) begin
      item = pixel_q.pop_front();
      in_word_i  <= item.pixel;
      in_valid_i <= 1'b1;
      if ($urandom_range(0, 63) == 0) in_burst = ~in_burst;
      gap_left = in_burst ? 0 : $urandom_range(0, 4);
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // Receiver stall: a fresh wait drawn for every result
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (out_took) begin
      if ($urandom_range(0, 63) == 0) out_burst = ~out_burst;
      stall_left = out_burst ? 0 : $urandom_range(0, 4);
      out_stall_i <= (stall_left > 0);
      if (stall_left > 0) stall_left = stall_left - 1;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      if (out_valid_o) stall_left = stall_left - 1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Monitor: predict on input accept, check on output accept
  always @(posedge clk_i) begin
    rhc_hsv_t want;
    logic     in_fire;
    logic     out_fire;
    in_fire  = rst_ni && in_valid_i && (in_stall_o === 1'b0);
    out_fire = rst_ni && (out_valid_o === 1'b1) && !out_stall_i;
    in_took  <= in_fire;
    out_took <= out_fire;
    if (in_fire) hsv_q.push_back(hsv_of(in_word_i));
    if (out_fire) begin
      if (hsv_q.size() == 0) begin
        report_mismatch("unexpected result, hue", int'(out_word_o.hue), 0);
      end else begin
        want = hsv_q.pop_front();
        if (out_word_o.hue !== want.hue)
          report_mismatch("hue", int'(out_word_o.hue), int'(want.hue));
        if (out_word_o.saturation !== want.saturation)
          report_mismatch("saturation", int'(out_word_o.saturation),
                          int'(want.saturation));
        if (out_word_o.value !== want.value)
          report_mismatch("value", int'(out_word_o.value), int'(want.value));
      end
    end
  end

  // Watchdog on cycles with no word moving on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

`default_nettype wire

### filelist.f
rtl/rhc_pkg.sv
rtl/rhc_front.sv
rtl/rhc_div_cell.sv
rtl/rhc_back.sv
rtl/rgb_to_hsv_converter.sv
bench/rgb_to_hsv_converter_tb.sv
